[rtl/pf_pkg.sv]
`timescale 1ns / 1ps

package pf_pkg;

    localparam int SIDE  = 5;
    localparam int CELLS = SIDE * SIDE;

    localparam int LETTER_W = 5;
    localparam int POS_W    = 3;
    localparam int INDEX_W  = 5;

    typedef logic [LETTER_W-1:0] t_letter;
    typedef logic [POS_W-1:0]    t_pos;
    typedef logic [INDEX_W-1:0]  t_index;

    typedef enum logic {
        ACT_LOAD    = 1'b0,
        ACT_ENCRYPT = 1'b1
    } t_action;

    // Row by row: M F H I J / U N O P Q / Z V W X Y / E L A R G / D S T B C
    localparam t_letter RESET_SQUARE [CELLS] = '{
        5'd12, 5'd5,  5'd7,  5'd8,  5'd9,
        5'd20, 5'd13, 5'd14, 5'd15, 5'd16,
        5'd25, 5'd21, 5'd22, 5'd23, 5'd24,
        5'd4,  5'd11, 5'd0,  5'd17, 5'd6,
        5'd3,  5'd18, 5'd19, 5'd1,  5'd2
    };

    // Step one place along a row or column, wrapping at the edge.
    function automatic t_pos pos_next(input t_pos p);
        return (p == t_pos'(SIDE - 1)) ? '0 : p + t_pos'(1);
    endfunction

    // Row-major cell index: row * 5 + col.
    function automatic t_index cell_idx(input t_pos row, input t_pos col);
        return {row, 2'b00} + {2'b00, row} + {2'b00, col};
    endfunction

endpackage

[rtl/playfair_digraph_encrypt_core.sv]
`timescale 1ns / 1ps

// Playfair digraph encryptor with a loadable 5x5 key square.
// An encrypt result passes the input register, then the output register, to the master side.
// Throughput: one item per cycle while the master side takes results; a load item yields no result.
// Reset (synchronous, active low): pipeline emptied, key square set to
// its fixed initial letters.
module playfair_digraph_encrypt_core
    import pf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [4:0] cell_index, [9:5] cell_letter, [14:10] first_letter,
    // [19:15] second_letter, [23:20] zero
    input  logic [23:0] i_s_axis_tdata,
    // [0] action
    input  logic        i_s_axis_tuser,

    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [4:0] first_cipher, [9:5] second_cipher, [15:10] zero
    output logic [15:0] o_m_axis_tdata,
    // [0] letter_missing
    output logic        o_m_axis_tuser
);

    t_letter r_key [CELLS];

    logic    r_in_valid;
    t_action r_action;
    t_index  r_cell_index;
    t_letter r_cell_letter;
    t_letter r_first;
    t_letter r_second;

    logic    r_out_valid;
    t_letter r_first_cipher;
    t_letter r_second_cipher;
    logic    r_missing;

    logic    s_go;
    logic    s_load_go;
    logic    s_enc_go;

    logic    found1, found2;
    t_pos    row1, col1, row2, col2;
    t_index  idx_a, idx_b;
    t_letter n_first_cipher, n_second_cipher;
    logic    n_missing;

    // Loads never wait on the output; an encrypt waits for a free result slot.
    assign s_go = r_in_valid &&
                  ((r_action == ACT_LOAD) || !r_out_valid || i_m_axis_tready);
    assign s_load_go = s_go && (r_action == ACT_LOAD);
    assign s_enc_go  = s_go && (r_action == ACT_ENCRYPT);

    assign o_s_axis_tready = !r_in_valid || s_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_action      <= t_action'(i_s_axis_tuser);
            r_cell_index  <= i_s_axis_tdata[4:0];
            r_cell_letter <= i_s_axis_tdata[9:5];
            r_first       <= i_s_axis_tdata[14:10];
            r_second      <= i_s_axis_tdata[19:15];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= RESET_SQUARE;
        end else if (s_load_go && (r_cell_index < t_index'(CELLS))) begin
            r_key[r_cell_index] <= r_cell_letter;
        end
    end

    // Parallel match; scanning downward leaves the first row-major hit.
    always_comb begin
        found1 = 1'b0;
        found2 = 1'b0;
        row1   = '0;
        col1   = '0;
        row2   = '0;
        col2   = '0;
        for (int k = CELLS - 1; k >= 0; k--) begin
            if (r_key[k] == r_first) begin
                found1 = 1'b1;
                row1   = t_pos'(k / SIDE);
                col1   = t_pos'(k % SIDE);
            end
            if (r_key[k] == r_second) begin
                found2 = 1'b1;
                row2   = t_pos'(k / SIDE);
                col2   = t_pos'(k % SIDE);
            end
        end
    end

    always_comb begin
        if (row1 == row2) begin
            idx_a = cell_idx(row1, pos_next(col1));
            idx_b = cell_idx(row2, pos_next(col2));
        end else if (col1 == col2) begin
            idx_a = cell_idx(pos_next(row1), col1);
            idx_b = cell_idx(pos_next(row2), col2);
        end else begin
            idx_a = cell_idx(row1, col2);
            idx_b = cell_idx(row2, col1);
        end
        n_missing = !(found1 && found2);
        if (n_missing) begin
            n_first_cipher  = '0;
            n_second_cipher = '0;
        end else begin
            n_first_cipher  = r_key[idx_a];
            n_second_cipher = r_key[idx_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_enc_go) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (s_enc_go) begin
            r_first_cipher  <= n_first_cipher;
            r_second_cipher <= n_second_cipher;
            r_missing       <= n_missing;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b0, r_second_cipher, r_first_cipher};
    assign o_m_axis_tuser  = r_missing;

    a_missing_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == 16'd0))
        else $error("missing letter with nonzero cipher");

    a_load_no_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && !s_enc_go) |=> !o_m_axis_tvalid)
        else $error("result produced without an encrypt item");

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_in_valid && !o_m_axis_tvalid))
        else $error("pipeline not empty after reset");

    a_stall_holds_input : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !s_go) |=> (r_in_valid && $stable(r_first) && $stable(r_second)))
        else $error("stalled item lost");

endmodule
